// ===== design/scgc_pkg.sv =====
// Shared types, constants and widths for the softened Coulomb grid accumulator.
// Used by scgc_unit, scgc_grid_mem and the top level; depends on nothing else.
package scgc_pkg;

	localparam int GRID_POINTS_DEF = 65536;

	localparam int SUM_W  = 48;
	localparam int WORD_W = SUM_W + 1;
	localparam int IDX_W  = 16;
	localparam int CRD_W  = 24;
	localparam int CHG_W  = 16;
	localparam int DSQ_W  = 50;
	localparam int SMAG_W = 46;
	localparam int RC_W   = 56;
	localparam int PW_W   = 57;

	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 64;

	localparam logic [30:0] SCALE_RESET = 31'd21762845;
	localparam logic signed [31:0] REP_RESET = 32'sd524288;
	localparam logic signed [31:0] ATT_RESET = -32'sd524288;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] REG_SCALE = 2'd0;
	localparam logic [1:0] REG_REP   = 2'd1;
	localparam logic [1:0] REG_ATT   = 2'd2;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic        start;
		logic        op;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_resp_t;

endpackage

// ===== design/scgc_unit.sv =====
// Shared arithmetic unit: registered 32x32 multiply, or 64/64 restoring
// divide at one quotient bit per cycle. Uses scgc_pkg request/response types.
module scgc_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scgc_pkg::unit_req_t  req,
	output scgc_pkg::unit_resp_t resp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic        done_q;
	logic [63:0] res_q;

	logic [64:0] shifted;
	logic [64:0] diff;
	logic        qbit;

	always_comb begin
		shifted = {rem_q, quo_q[63]};
		diff    = shifted - {1'b0, den_q};
		qbit    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				if (req.op == scgc_pkg::OP_DIV) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= qbit ? diff[63:0] : shifted[63:0];
			quo_q <= {quo_q[62:0], qbit};
			if (cnt_q == 6'd63)
				res_q <= {quo_q[62:0], qbit};
		end else if (req.start) begin
			if (req.op == scgc_pkg::OP_DIV) begin
				rem_q <= '0;
				quo_q <= req.a;
				den_q <= req.b;
			end else begin
				res_q <= req.a[31:0] * req.b[31:0];
			end
		end
	end

	assign resp.done   = done_q;
	assign resp.result = res_q;

endmodule

// ===== design/scgc_grid_mem.sv =====
// Per-grid-point storage: saturation mark and 48-bit sum in one word.
// Runs a clearing pass after reset; uses scgc_pkg for word width.
module scgc_grid_mem #(
	parameter int GRID_POINTS = scgc_pkg::GRID_POINTS_DEF,
	parameter int ADDR_W      = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [scgc_pkg::WORD_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [scgc_pkg::WORD_W-1:0] wr_data,
	output logic                        clearing
);

	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(GRID_POINTS - 1);

	logic [scgc_pkg::WORD_W-1:0] mem [GRID_POINTS];
	logic                        clr_q;
	logic [ADDR_W-1:0]           clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST)
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_addr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign clearing = clr_q;

endmodule

// ===== design/soft_cutoff_coulomb_grid_accumulator.sv =====
// Top level: command decode, sequencer over the shared unit, result register.
// Depends on scgc_pkg, scgc_unit and scgc_grid_mem.
//
//  channel  | signals                            | word
//  ---------+------------------------------------+---------------------------------
//  s (in)   | s_tvalid s_tready s_tdata s_tuser  | command, index, positions, charge
//  m (out)  | m_tvalid m_tready m_tdata m_tuser  | entry index, sum, overflow mark
//  cfg      | cfg_valid cfg_ready cfg_index/data | register write
//
// A read, an out-of-range index, zero charge or zero maximum goes straight to
// the done state. An accumulate beyond the cutoff runs four multiplies and two
// divides in the shared radix-2 unit. Inside the cutoff the second divide forms
// the slope and three more multiplies follow; a cutoff of zero with a distance
// of zero stops after the first divide.
// After reset a clearing pass over every grid entry runs before s_tready rises.
// A stalled m side holds the finished word; the next input waits for it.
module soft_cutoff_coulomb_grid_accumulator #(
	parameter int GRID_POINTS = scgc_pkg::GRID_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// grid_index, grid_x, grid_y, grid_z, atom_x, atom_y, atom_z, atom_charge
	input  logic [scgc_pkg::S_TDATA_W-1:0] s_tdata,
	// command
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// entry_index, entry_sum
	output logic [scgc_pkg::M_TDATA_W-1:0] m_tdata,
	// overflowed
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int ADDR_W = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MX   = 4'd1;
	localparam logic [3:0] ST_MY   = 4'd2;
	localparam logic [3:0] ST_MZ   = 4'd3;
	localparam logic [3:0] ST_MS   = 4'd4;
	localparam logic [3:0] ST_DRC  = 4'd5;
	localparam logic [3:0] ST_DE   = 4'd6;
	localparam logic [3:0] ST_DA   = 4'd7;
	localparam logic [3:0] ST_T0   = 4'd8;
	localparam logic [3:0] ST_T1   = 4'd9;
	localparam logic [3:0] ST_T2   = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	function automatic logic signed [scgc_pkg::PW_W-1:0] PW_W_EXT(logic signed [31:0] v);
		return scgc_pkg::PW_W'(v);
	endfunction

	// configuration
	logic [30:0]        scale_q;
	logic signed [31:0] rep_q;
	logic signed [31:0] att_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= scgc_pkg::SCALE_RESET;
			rep_q   <= scgc_pkg::REP_RESET;
			att_q   <= scgc_pkg::ATT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scgc_pkg::REG_SCALE: scale_q <= cfg_data[30:0];
				scgc_pkg::REG_REP:   rep_q   <= cfg_data;
				scgc_pkg::REG_ATT:   att_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input unpacking
	logic [15:0]        in_idx;
	logic signed [23:0] gx, gy, gz, ax, ay, az;
	logic signed [15:0] in_q;
	logic signed [24:0] dx, dy, dz;
	logic [24:0]        dxm, dym, dzm;
	logic [16:0]        qneg;
	logic [15:0]        qmag;
	logic signed [31:0] msel;
	logic [32:0]        mneg;
	logic [31:0]        mmag;
	logic [31:0]        idx32;
	logic               in_range;

	always_comb begin
		in_idx = s_tdata[15:0];
		gx     = s_tdata[39:16];
		gy     = s_tdata[63:40];
		gz     = s_tdata[87:64];
		ax     = s_tdata[111:88];
		ay     = s_tdata[135:112];
		az     = s_tdata[159:136];
		in_q   = s_tdata[175:160];
		dx     = 25'(gx) - 25'(ax);
		dy     = 25'(gy) - 25'(ay);
		dz     = 25'(gz) - 25'(az);
		dxm    = dx[24] ? 25'(-dx) : 25'(dx);
		dym    = dy[24] ? 25'(-dy) : 25'(dy);
		dzm    = dz[24] ? 25'(-dz) : 25'(dz);
		qneg   = -17'(in_q);
		qmag   = in_q[15] ? qneg[15:0] : 16'(in_q);
		msel   = (in_q > 16'sd0) ? rep_q : att_q;
		mneg   = -33'(msel);
		mmag   = msel[31] ? mneg[31:0] : 32'(msel);
		idx32  = 32'(in_idx);
		in_range = (idx32 < GRID_POINTS);
	end

	// item registers
	logic [3:0]               state_q;
	logic                     wait_q;
	logic                     cmd_q;
	logic                     range_q;
	logic [15:0]              idx_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [24:0]              dxm_q, dym_q, dzm_q;
	logic [15:0]              qmag_q;
	logic                     qpos_q;
	logic signed [31:0]       m_q;
	logic [31:0]              mmag_q;
	logic [scgc_pkg::DSQ_W-1:0]  d_q;
	logic [scgc_pkg::SMAG_W-1:0] s_q;
	logic [scgc_pkg::RC_W-1:0]   rc_q;
	logic [62:0]              a_q;
	logic [63:0]              acc_q;
	logic signed [scgc_pkg::PW_W-1:0] p_q;

	logic                  accept;
	logic                  mem_clearing;
	logic [scgc_pkg::WORD_W-1:0] rd_data;
	logic                  out_free;

	scgc_pkg::unit_req_t  req;
	scgc_pkg::unit_resp_t resp;

	assign s_tready = (state_q == ST_IDLE) && !mem_clearing;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// shared unit operands
	always_comb begin
		req.start = (state_q != ST_IDLE) && (state_q != ST_DONE) && !wait_q;
		req.op    = scgc_pkg::OP_MUL;
		req.a     = '0;
		req.b     = '0;
		unique case (state_q)
			ST_MX: begin
				req.a = 64'(dxm_q);
				req.b = 64'(dxm_q);
			end
			ST_MY: begin
				req.a = 64'(dym_q);
				req.b = 64'(dym_q);
			end
			ST_MZ: begin
				req.a = 64'(dzm_q);
				req.b = 64'(dzm_q);
			end
			ST_MS: begin
				req.a = 64'(scale_q);
				req.b = 64'(qmag_q);
			end
			ST_DRC: begin
				req.op = scgc_pkg::OP_DIV;
				req.a  = {9'd0, s_q, 9'd0};
				req.b  = 64'(mmag_q);
			end
			ST_DE: begin
				req.op = scgc_pkg::OP_DIV;
				req.a  = {10'd0, s_q, 8'd0};
				req.b  = 64'(d_q);
			end
			ST_DA: begin
				req.op = scgc_pkg::OP_DIV;
				req.a  = {mmag_q, 32'd0};
				req.b  = {7'd0, rc_q, 1'b0};
			end
			ST_T0: begin
				req.a = 64'(a_q[31:0]);
				req.b = 64'(d_q[31:0]);
			end
			ST_T1: begin
				req.a = 64'(a_q[31:0]);
				req.b = 64'(d_q[49:32]);
			end
			ST_T2: begin
				req.a = 64'(a_q[62:32]);
				req.b = 64'(d_q[31:0]);
			end
			default: ;
		endcase
	end

	scgc_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.resp   (resp)
	);

	// near-slope finish and result arithmetic
	logic [63:0]                      acc_next;
	logic [31:0]                      t_val;
	logic signed [scgc_pkg::PW_W-1:0] p_near;
	logic signed [scgc_pkg::PW_W-1:0] e_sgn;
	logic signed [57:0]               s_sum;
	logic signed [scgc_pkg::SUM_W-1:0] sum_new;
	logic                             sat;
	logic [scgc_pkg::SUM_W-1:0]       out_sum;
	logic                             out_flag;
	logic [scgc_pkg::WORD_W-1:0]      wr_data;
	logic                             wr_en;

	always_comb begin
		acc_next = acc_q + {resp.result[31:0], 32'd0};
		t_val    = acc_next[63:32];
		p_near   = qpos_q ? (PW_W_EXT(m_q) - 57'(t_val)) : (PW_W_EXT(m_q) + 57'(t_val));
		e_sgn    = qpos_q ? 57'(resp.result[54:0]) : -57'(resp.result[54:0]);

		s_sum = 58'($signed(rd_data[scgc_pkg::SUM_W-1:0])) + 58'(p_q);
		sat   = 1'b0;
		if (s_sum > 58'(scgc_pkg::SUM_MAX)) begin
			sum_new = scgc_pkg::SUM_MAX;
			sat     = 1'b1;
		end else if (s_sum < 58'(scgc_pkg::SUM_MIN)) begin
			sum_new = scgc_pkg::SUM_MIN;
			sat     = 1'b1;
		end else begin
			sum_new = s_sum[scgc_pkg::SUM_W-1:0];
		end

		wr_en = (state_q == ST_DONE) && out_free && range_q;
		if (!range_q) begin
			out_sum  = '0;
			out_flag = 1'b0;
			wr_data  = '0;
		end else if (cmd_q == scgc_pkg::CMD_READ) begin
			out_sum  = rd_data[scgc_pkg::SUM_W-1:0];
			out_flag = rd_data[scgc_pkg::SUM_W];
			wr_data  = '0;
		end else begin
			out_sum  = sum_new;
			out_flag = rd_data[scgc_pkg::SUM_W] | sat;
			wr_data  = {out_flag, sum_new};
		end
	end

	scgc_grid_mem #(
		.GRID_POINTS (GRID_POINTS),
		.ADDR_W      (ADDR_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (idx32[ADDR_W-1:0]),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_q),
		.wr_data  (wr_data),
		.clearing (mem_clearing)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= 1'b0;
		end else begin
			if (req.start)
				wait_q <= 1'b1;
			if (resp.done)
				wait_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == scgc_pkg::CMD_ACCUM && in_range &&
						    in_q != 16'sd0 && msel != 32'sd0)
							state_q <= ST_MX;
						else
							state_q <= ST_DONE;
					end
				end
				ST_MX: if (resp.done) state_q <= ST_MY;
				ST_MY: if (resp.done) state_q <= ST_MZ;
				ST_MZ: if (resp.done) state_q <= ST_MS;
				ST_MS: if (resp.done) state_q <= ST_DRC;
				ST_DRC: begin
					if (resp.done) begin
						if (64'(d_q) > resp.result)
							state_q <= ST_DE;
						else if (resp.result == 64'd0)
							state_q <= ST_DONE;
						else
							state_q <= ST_DA;
					end
				end
				ST_DE: if (resp.done) state_q <= ST_DONE;
				ST_DA: if (resp.done) state_q <= ST_T0;
				ST_T0: if (resp.done) state_q <= ST_T1;
				ST_T1: if (resp.done) state_q <= ST_T2;
				ST_T2: if (resp.done) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			range_q <= in_range;
			idx_q   <= in_idx;
			addr_q  <= idx32[ADDR_W-1:0];
			dxm_q   <= dxm;
			dym_q   <= dym;
			dzm_q   <= dzm;
			qmag_q  <= qmag;
			qpos_q  <= (in_q > 16'sd0);
			m_q     <= msel;
			mmag_q  <= mmag;
			p_q     <= '0;
		end
		if (resp.done) begin
			unique case (state_q)
				ST_MX:  d_q <= resp.result[scgc_pkg::DSQ_W-1:0];
				ST_MY,
				ST_MZ:  d_q <= d_q + resp.result[scgc_pkg::DSQ_W-1:0];
				ST_MS:  s_q <= resp.result[scgc_pkg::SMAG_W-1:0];
				ST_DRC: begin
					rc_q <= resp.result[scgc_pkg::RC_W-1:0];
					// cutoff of zero: slope is zero, potential is the cap
					p_q  <= PW_W_EXT(m_q);
				end
				ST_DE:  p_q <= e_sgn;
				ST_DA:  a_q <= resp.result[62:0];
				ST_T0:  acc_q <= resp.result;
				ST_T1:  acc_q <= acc_next;
				ST_T2:  p_q <= p_near;
				default: ;
			endcase
		end
	end

	// result register
	logic        out_valid_q;
	logic [15:0] out_idx_q;
	logic [scgc_pkg::SUM_W-1:0] out_sum_q;
	logic        out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_idx_q  <= idx_q;
			out_sum_q  <= out_sum;
			out_flag_q <= out_flag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sum_q, out_idx_q};
	assign m_tuser  = out_flag_q;

endmodule
